/* rtl/core/timed_phase_sequencer_top_assert.svh */
// assertion macros for the timed phase sequencer
`ifndef TIMED_PHASE_SEQUENCER_TOP_ASSERT_SVH
`define TIMED_PHASE_SEQUENCER_TOP_ASSERT_SVH
`ifndef SYNTH
`define TPS_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("tps check failed");
`define TPS_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("tps check failed");
`else
`define TPS_ASSERT_IMPL(label, clk, rst_n, a, c)
`define TPS_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

/* rtl/core/tps_pkg.sv */
// ----------------------------------------------------------------------------
// tps_pkg
// shared constants and codes of the timed phase sequencer
// ----------------------------------------------------------------------------
package tps_pkg;
    localparam int SCENE_SLOTS_DEF = 4;
    localparam int MAX_PHASES_DEF  = 8;
    localparam int RESULT_LIMIT    = 64;
    localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_STOP  = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    localparam logic [2:0] EV_SCENE_BEGIN   = 3'd0;
    localparam logic [2:0] EV_PHASE_BEGIN   = 3'd1;
    localparam logic [2:0] EV_PHASE_END     = 3'd2;
    localparam logic [2:0] EV_SCENE_END     = 3'd3;
    localparam logic [2:0] EV_TABLE_FULL    = 3'd4;
    localparam logic [2:0] EV_LIST_OVERFLOW = 3'd5;
endpackage

/* rtl/core/tps_ram.sv */
// ----------------------------------------------------------------------------
// tps_ram
// generic single-port-write ram with registered read
// ----------------------------------------------------------------------------
module tps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/core/timed_phase_sequencer_top.sv */
// ----------------------------------------------------------------------------
// timed_phase_sequencer_top
// table of timed phase sequences driven by start, stop and tick beats
// ----------------------------------------------------------------------------
// channel   dir  tdata (low bit up)                              tuser
// s_axis    in   handle[63:0] phase_id[95:64] period[127:96]      mode[1:0] phase_valid[2]
//                delta_time[159:128]                               last_entry as tlast
// m_axis    out  scene[63:0] phase[95:64]                          event_res[2:0], last as tlast
//
// one beat at a time: a small sequencer walks the slots one per step,
// a shared compare unit matches handles and a shared add/compare unit
// updates timers; a start that opens a load scans the slots for its handle
// and then for a free slot, a stop scans for its handle, and a tick adds and
// compares per active slot and reads the ram for each phase event of a fired
// transition; each beat with results ends by releasing the final one as last
// the phase list lives in one ram with registered read
// reset is synchronous active low and clears valid bits and control only
// s_axis_tready is high only in idle; each result passes a one-beat stage
// before the output register, so last is known when it leaves; a full stage
// with a held output beat holds back the next result until m_axis takes it
// ----------------------------------------------------------------------------
module timed_phase_sequencer_top
    import tps_pkg::*;
#(
    parameter int SCENE_SLOTS = SCENE_SLOTS_DEF,
    parameter int MAX_PHASES  = MAX_PHASES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [159:0] s_axis_tdata,   // handle, phase_id, period, delta_time
    input  logic [2:0]   s_axis_tuser,   // mode, phase_valid
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,   // scene, phase
    output logic [2:0]   m_axis_tuser,   // event_res
    output logic         m_axis_tlast
);
    `include "timed_phase_sequencer_top_assert.svh"

    localparam int SW = (SCENE_SLOTS > 1) ? $clog2(SCENE_SLOTS) : 1;
    localparam int PW = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
    localparam int LW = $clog2(MAX_PHASES + 1);
    localparam int DEPTH = SCENE_SLOTS * MAX_PHASES;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(RESULT_LIMIT + 1);

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FIND   = 4'd1;  // same-handle scan
    localparam logic [3:0] S_FREE   = 4'd2;  // free slot scan
    localparam logic [3:0] S_LOAD   = 4'd3;  // append phase
    localparam logic [3:0] S_ACT    = 4'd4;  // activation events
    localparam logic [3:0] S_STOP   = 4'd5;
    localparam logic [3:0] S_TADD   = 4'd6;  // timer add
    localparam logic [3:0] S_TCHK   = 4'd7;  // due compare
    localparam logic [3:0] S_RD     = 4'd8;  // ram read wait
    localparam logic [3:0] S_EMIT   = 4'd9;  // push ram phase event
    localparam logic [3:0] S_EMIT2  = 4'd10; // second event
    localparam logic [3:0] S_DONE   = 4'd11;
    localparam logic [3:0] S_FLUSH  = 4'd12; // release staged result as last

    // next-action codes after a ram read
    localparam logic [1:0] K_ACT  = 2'd0;
    localparam logic [1:0] K_STOP = 2'd1;
    localparam logic [1:0] K_TEND = 2'd2;
    localparam logic [1:0] K_TBEG = 2'd3;

    logic [3:0] r_state;
    logic [SCENE_SLOTS-1:0] r_used;
    logic [63:0] r_handle [SCENE_SLOTS];
    logic signed [31:0] r_period [SCENE_SLOTS];
    logic signed [31:0] r_timer [SCENE_SLOTS];
    logic [LW-1:0] r_pos [SCENE_SLOTS];
    logic [LW-1:0] r_len [SCENE_SLOTS];
    logic r_loading;
    logic [SW-1:0] r_lslot;
    logic [SW-1:0] r_idx;
    logic [1:0] r_kind;
    logic [CW-1:0] r_cnt;

    // latched beat
    logic [63:0] r_h;
    logic [31:0] r_pid;
    logic signed [31:0] r_per;
    logic signed [31:0] r_dt;
    logic r_pv, r_le;

    // result stage, holds the newest result until the next one or the end
    logic r_sv;
    logic [2:0] r_sev;
    logic [63:0] r_ssc;
    logic [31:0] r_sph;

    // output register
    logic r_ov;
    logic [2:0] r_oev;
    logic [63:0] r_osc;
    logic [31:0] r_oph;
    logic r_olast;

    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0] ram_rdata;

    tps_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_phase_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(r_pid),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    function automatic logic [AW-1:0] addr(logic [SW-1:0] s, logic [LW-1:0] p);
        logic [AW+LW:0] a;
        a = (AW+LW+1)'(s) * (AW+LW+1)'(MAX_PHASES) + (AW+LW+1)'(p);
        return a[AW-1:0];
    endfunction

    // shared unit: handle compare and saturating timer add
    logic hmatch;
    logic signed [32:0] sum;
    logic signed [31:0] sat;
    logic last_slot;
    assign hmatch = (r_handle[r_idx] == r_h);
    assign sum = 33'(r_timer[r_idx]) + 33'(r_dt);
    assign sat = (sum > 33'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                 (sum < -33'sh0_8000_0000) ? 32'sh8000_0000 : sum[31:0];
    assign last_slot = (32'(r_idx) == SCENE_SLOTS - 1);

    logic can_push;
    assign can_push = !r_ov || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {r_oph, r_osc};
    assign m_axis_tuser  = r_oev;
    assign m_axis_tlast  = r_olast;

    // fire condition for the current slot in a tick
    logic due;
    assign due = r_used[r_idx] && (r_pos[r_idx] < r_len[r_idx]) &&
                 (r_timer[r_idx] >= r_period[r_idx]) && (32'(r_cnt) + 2 <= RESULT_LIMIT);

    // valid phase with a full list
    logic ovf;
    assign ovf = r_pv && (r_len[r_lslot] >= LW'(MAX_PHASES));

    // result wanted by the current state
    logic e_want;
    logic [2:0] e_ev;
    logic [63:0] e_sc;
    logic [31:0] e_ph;
    always_comb begin
        e_want = 1'b0;
        e_ev = EV_SCENE_BEGIN;
        e_sc = r_handle[r_idx];
        e_ph = '0;
        case (r_state)
            S_FREE: begin
                if (r_used[r_idx] && last_slot) begin
                    e_want = 1'b1;
                    e_ev = EV_TABLE_FULL;
                    e_sc = r_h;
                end
            end
            S_LOAD: begin
                if (ovf) begin
                    e_want = 1'b1;
                    e_ev = EV_LIST_OVERFLOW;
                    e_sc = r_handle[r_lslot];
                    e_ph = r_pid;
                end
            end
            S_ACT: e_want = 1'b1;
            S_EMIT: begin
                e_want = 1'b1;
                e_ev = (r_kind inside {K_STOP, K_TEND}) ? EV_PHASE_END : EV_PHASE_BEGIN;
                e_ph = ram_rdata;
            end
            S_EMIT2: begin
                e_want = 1'b1;
                e_ev = EV_SCENE_END;
            end
            default: ;
        endcase
    end

    // a staged result moves to the output register when the next result
    // arrives (not last) or when the beat's work ends (last)
    logic e_go, f_go, push_out;
    assign e_go = e_want && (!r_sv || can_push);
    assign f_go = (r_state == S_FLUSH) && r_sv && can_push;
    assign push_out = r_sv && (e_go || f_go);

    always_comb begin
        ram_we = 1'b0;
        ram_waddr = addr(r_lslot, r_len[r_lslot]);
        ram_raddr = addr(r_idx, r_pos[r_idx]);
        if (r_state == S_LOAD && r_pv && !ovf) ram_we = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used <= '0;
            r_loading <= 1'b0;
            r_ov <= 1'b0;
            r_sv <= 1'b0;
            r_lslot <= '0;
            r_idx <= '0;
            r_cnt <= '0;
        end else begin
            // output register and stage
            if (push_out) begin
                r_ov <= 1'b1; r_oev <= r_sev; r_osc <= r_ssc; r_oph <= r_sph;
                r_olast <= f_go;
            end else if (r_ov && m_axis_tready) r_ov <= 1'b0;
            if (e_go) begin
                r_sv <= 1'b1; r_sev <= e_ev; r_ssc <= e_sc; r_sph <= e_ph;
            end else if (f_go) r_sv <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_pv <= s_axis_tuser[2];
                        r_le <= s_axis_tlast;
                        r_h <= s_axis_tdata[63:0];
                        r_pid <= s_axis_tdata[95:64];
                        r_per <= s_axis_tdata[127:96];
                        r_dt <= s_axis_tdata[159:128];
                        r_idx <= '0;
                        r_cnt <= '0;
                        case (s_axis_tuser[1:0])
                            MODE_START: r_state <= r_loading ? S_LOAD : S_FIND;
                            MODE_STOP:  r_state <= S_STOP;
                            MODE_TICK:  r_state <= S_TADD;
                            default:    r_state <= S_IDLE;
                        endcase
                    end
                end
                S_FIND: begin
                    if (r_used[r_idx] && hmatch) begin
                        r_lslot <= r_idx;
                        r_state <= S_DONE; // begin load below
                    end else if (last_slot) begin
                        r_idx <= '0;
                        r_state <= S_FREE;
                    end else r_idx <= r_idx + 1'b1;
                end
                S_FREE: begin
                    if (!r_used[r_idx]) begin
                        r_lslot <= r_idx;
                        r_state <= S_DONE;
                    end else if (last_slot) begin
                        // table full result staged by the event decode
                        if (e_go) r_state <= S_FLUSH;
                    end else r_idx <= r_idx + 1'b1;
                end
                S_DONE: begin
                    // start a fresh load in slot r_lslot
                    r_used[r_lslot] <= 1'b0;
                    r_handle[r_lslot] <= r_h;
                    r_len[r_lslot] <= '0;
                    r_loading <= 1'b1;
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    if (!ovf || e_go) begin
                        r_period[r_lslot] <= (r_per > 0) ? r_per : ONE_Q16;
                        if (r_pv && !ovf) r_len[r_lslot] <= r_len[r_lslot] + 1'b1;
                        if (r_le) begin
                            r_idx <= r_lslot;
                            r_state <= S_ACT;
                        end else r_state <= S_FLUSH;
                    end
                end
                S_ACT: begin
                    // scene begin
                    if (e_go) begin
                        r_loading <= 1'b0;
                        r_timer[r_idx] <= '0;
                        r_pos[r_idx] <= '0;
                        r_kind <= K_ACT;
                        if (r_len[r_idx] == '0) r_state <= S_EMIT2;
                        else begin
                            r_used[r_idx] <= 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                S_STOP: begin
                    if (r_used[r_idx] && hmatch) begin
                        r_used[r_idx] <= 1'b0;
                        r_kind <= K_STOP;
                        r_state <= (r_pos[r_idx] < r_len[r_idx]) ? S_RD : S_EMIT2;
                    end else if (last_slot) r_state <= S_IDLE;
                    else r_idx <= r_idx + 1'b1;
                end
                S_TADD: begin
                    if (r_used[r_idx]) begin
                        r_timer[r_idx] <= sat;
                        r_state <= S_TCHK;
                    end else if (last_slot) r_state <= S_FLUSH;
                    else r_idx <= r_idx + 1'b1;
                end
                S_TCHK: begin
                    if (due) begin
                        r_timer[r_idx] <= r_timer[r_idx] - r_period[r_idx];
                        r_kind <= K_TEND;
                        r_state <= S_RD;
                    end else if (last_slot) r_state <= S_FLUSH;
                    else begin
                        r_idx <= r_idx + 1'b1;
                        r_state <= S_TADD;
                    end
                end
                S_RD: r_state <= S_EMIT;
                S_EMIT: begin
                    // phase begin or phase end with the id read from the ram
                    if (e_go) begin
                        r_cnt <= r_cnt + 1'b1;
                        case (r_kind)
                            K_ACT:  r_state <= S_FLUSH;
                            K_STOP: r_state <= S_EMIT2;
                            K_TEND: begin
                                r_pos[r_idx] <= r_pos[r_idx] + 1'b1;
                                if (r_pos[r_idx] + 1'b1 < r_len[r_idx]) begin
                                    r_kind <= K_TBEG;
                                    r_state <= S_RD;
                                end else begin
                                    r_used[r_idx] <= 1'b0;
                                    r_state <= S_EMIT2;
                                end
                            end
                            default: r_state <= S_TCHK;
                        endcase
                    end
                end
                S_EMIT2: begin
                    // scene end
                    if (e_go) begin
                        r_cnt <= r_cnt + 1'b1;
                        r_state <= (r_kind == K_TEND) ? S_TCHK : S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    if (!r_sv || can_push) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `TPS_ASSERT_IMPL(a_ready_idle, i_clk, i_rst_n, s_axis_tready, r_state == S_IDLE)
    `TPS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, r_ov && !m_axis_tready, r_ov)
    `TPS_ASSERT_IMPL(a_cnt, i_clk, i_rst_n, r_state != S_IDLE, 32'(r_cnt) <= RESULT_LIMIT)
    `TPS_ASSERT_IMPL(a_stage_idle, i_clk, i_rst_n, r_state == S_IDLE, !r_sv)
endmodule

/* bench/tps_scoreboard.sv */
// ----------------------------------------------------------------------------
// tps_scoreboard
// predicts the event beats of the timed phase sequencer and checks them
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import tps_pkg::*;

class tps_scoreboard;
    typedef struct packed {
        logic [2:0]  ev;
        logic [63:0] scene;
        logic [31:0] phase;
        logic        last;
    } t_event;

    bit               used [SCENE_SLOTS_DEF];
    logic [63:0]      handle_q [SCENE_SLOTS_DEF];
    logic signed [31:0] period_q [SCENE_SLOTS_DEF];
    logic signed [31:0] timer_q [SCENE_SLOTS_DEF];
    int unsigned      pos_q [SCENE_SLOTS_DEF];
    int unsigned      len_q [SCENE_SLOTS_DEF];
    logic [31:0]      phases [SCENE_SLOTS_DEF][MAX_PHASES_DEF];
    int unsigned      loading;
    t_event           pending_events[$];
    t_event           batch[$];
    int               errors;

    function new();
        foreach (used[s]) used[s] = 0;
        loading = 0;
        errors  = 0;
    endfunction

    function void add_event(logic [2:0] ev, logic [63:0] sc, logic [31:0] ph);
        t_event e;
        if (batch.size() >= RESULT_LIMIT) return;
        e.ev = ev; e.scene = sc; e.phase = ph; e.last = 0;
        batch.insert(batch.size(), e);
    endfunction

    function void start_beat(logic [63:0] h, logic [31:0] id, bit pv, bit le,
                             logic signed [31:0] per);
        int unsigned s;
        int          pick;
        pick = -1;
        if (loading == 0) begin
            for (int i = 0; i < SCENE_SLOTS_DEF && pick < 0; i++)
                if (used[i] && handle_q[i] == h) pick = i;
            for (int i = 0; i < SCENE_SLOTS_DEF && pick < 0; i++)
                if (!used[i]) pick = i;
            if (pick < 0) begin
                add_event(EV_TABLE_FULL, h, '0);
                return;
            end
            used[pick] = 0; handle_q[pick] = h; timer_q[pick] = 0;
            pos_q[pick] = 0; len_q[pick] = 0;
            loading = pick + 1;
        end
        s = loading - 1;
        period_q[s] = (per > 0) ? per : ONE_Q16;
        if (pv) begin
            if (len_q[s] < MAX_PHASES_DEF) begin
                phases[s][len_q[s]] = id;
                len_q[s]++;
            end else begin
                add_event(EV_LIST_OVERFLOW, handle_q[s], id);
            end
        end
        if (le) begin
            loading = 0; timer_q[s] = 0; pos_q[s] = 0;
            add_event(EV_SCENE_BEGIN, handle_q[s], '0);
            if (len_q[s] == 0) add_event(EV_SCENE_END, handle_q[s], '0);
            else begin
                used[s] = 1;
                add_event(EV_PHASE_BEGIN, handle_q[s], phases[s][0]);
            end
        end
    endfunction

    function void stop_beat(logic [63:0] h);
        for (int s = 0; s < SCENE_SLOTS_DEF; s++)
            if (used[s] && handle_q[s] == h) begin
                used[s] = 0;
                if (pos_q[s] < len_q[s]) add_event(EV_PHASE_END, h, phases[s][pos_q[s]]);
                add_event(EV_SCENE_END, h, '0);
                return;
            end
    endfunction

    function void tick_beat(logic signed [31:0] dt);
        longint t;
        for (int s = 0; s < SCENE_SLOTS_DEF; s++) begin
            if (!used[s]) continue;
            t = longint'(timer_q[s]) + longint'(dt);
            if (t > 64'sd2147483647) t = 64'sd2147483647;
            if (t < -64'sd2147483648) t = -64'sd2147483648;
            timer_q[s] = t[31:0];
            while (used[s] && pos_q[s] < len_q[s] && timer_q[s] >= period_q[s]
                   && batch.size() + 2 <= RESULT_LIMIT) begin
                timer_q[s] = timer_q[s] - period_q[s];
                add_event(EV_PHASE_END, handle_q[s], phases[s][pos_q[s]]);
                pos_q[s]++;
                if (pos_q[s] < len_q[s])
                    add_event(EV_PHASE_BEGIN, handle_q[s], phases[s][pos_q[s]]);
                else begin
                    used[s] = 0;
                    add_event(EV_SCENE_END, handle_q[s], '0);
                end
            end
        end
    endfunction

    // note one accepted input beat and queue the events it causes
    function void note_input(logic [159:0] data, logic [2:0] user, bit tlast);
        batch.delete();
        case (user[1:0])
            MODE_START: start_beat(data[63:0], data[95:64], user[2], tlast, data[127:96]);
            MODE_STOP:  stop_beat(data[63:0]);
            MODE_TICK:  tick_beat(data[159:128]);
            default: ;
        endcase
        if (batch.size() > 0) batch[batch.size() - 1].last = 1;
        foreach (batch[i]) pending_events.insert(pending_events.size(), batch[i]);
    endfunction

    function void check_event(logic [95:0] data, logic [2:0] user, bit tlast);
        t_event e;
        if (pending_events.size() == 0) begin
            $error("unexpected event beat ev=%0d scene=%h", user, data[63:0]);
            errors++;
            return;
        end
        e = pending_events.pop_front();
        if (user != e.ev) begin
            $error("event_res expected %0d actual %0d", e.ev, user); errors++;
        end
        if (data[63:0] != e.scene) begin
            $error("scene expected %h actual %h", e.scene, data[63:0]); errors++;
        end
        if (data[95:64] != e.phase) begin
            $error("phase expected %h actual %h", e.phase, data[95:64]); errors++;
        end
        if (tlast != e.last) begin
            $error("last expected %0d actual %0d", e.last, tlast); errors++;
        end
    endfunction
endclass

/* bench/tb_timed_phase_sequencer_top.sv */
// ----------------------------------------------------------------------------
// tb_timed_phase_sequencer_top
// drives start, stop and tick beats with random gaps and back pressure and
// checks every event beat against a behavioral prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_timed_phase_sequencer_top;
    import tps_pkg::*;

    localparam longint CYCLE_LIMIT = 2000000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [159:0] s_axis_tdata;   // handle, phase_id, period, delta_time
    logic [2:0]   s_axis_tuser;   // mode, phase_valid
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;   // scene, phase
    logic [2:0]   m_axis_tuser;   // event_res
    logic         m_axis_tlast;

    tps_scoreboard event_board;
    int            send_idle_pct;
    int            take_idle_pct;
    longint        cycles = 0;
    logic [63:0]   handle_pool [6];

    timed_phase_sequencer_top i_dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle limit guards against a hung handshake
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // event side: sample at the rising edge, change ready at the falling edge
    always @(posedge i_clk)
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            event_board.check_event(m_axis_tdata, m_axis_tuser, m_axis_tlast);

    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= take_idle_pct);

    // send one beat, holding it until taken; at the following falling edge the
    // next beat drives new data or lowers valid, or the caller lowers valid
    task automatic send_beat(logic [1:0] mode, logic [63:0] h, logic [31:0] id,
                             bit pv, bit le, logic [31:0] per, logic [31:0] dt);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {dt, per, id, h};
        s_axis_tuser  <= {pv, mode};
        s_axis_tlast  <= le;
        do @(posedge i_clk); while (!s_axis_tready);
        event_board.note_input({dt, per, id, h}, {pv, mode}, le);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_period();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h0;
            2: return $urandom & 32'h7fff_ffff;
            default: return $urandom_range(32'h0003_0000, 1);
        endcase
    endfunction

    function automatic logic [31:0] rand_dt();
        case ($urandom_range(11))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom;
            3: return -$urandom_range(32'h0002_0000);
            default: return $urandom_range(32'h0004_0000);
        endcase
    endfunction

    // a full load: mostly short well-formed lists, now and then overflowing
    task automatic load_sequence(logic [63:0] h);
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(12, 9) : $urandom_range(4);
        if (n == 0) begin
            send_beat(MODE_START, h, $urandom, 0, 1, rand_period(), $urandom);
            return;
        end
        for (int i = 0; i < n; i++)
            send_beat(MODE_START, h, $urandom, $urandom_range(5) != 0, i == n - 1,
                      rand_period(), $urandom);
    endtask

    task automatic random_phase(int items);
        int k;
        k = 0;
        while (k < items) begin
            case ($urandom_range(9))
                0, 1, 2: begin
                    load_sequence(handle_pool[$urandom_range(5)]);
                    k += 3;
                end
                3: begin
                    send_beat(MODE_STOP, handle_pool[$urandom_range(5)], $urandom, 0, 0,
                              $urandom, $urandom);
                    k++;
                end
                4: begin
                    // noise: random stop handle or unknown mode
                    send_beat($urandom_range(1) ? 2'd3 : MODE_STOP, {$urandom, $urandom},
                              $urandom, 1'($urandom), 1'($urandom), $urandom, $urandom);
                    k++;
                end
                default: begin
                    send_beat(MODE_TICK, {$urandom, $urandom}, $urandom, 1'($urandom), 0,
                              $urandom, rand_dt());
                    k++;
                end
            endcase
        end
    endtask

    initial begin
        event_board   = new();
        i_rst_n       = 0;
        s_axis_tvalid = 0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 0;
        m_axis_tready = 0;
        send_idle_pct = 0;
        take_idle_pct = 0;
        foreach (handle_pool[i]) handle_pool[i] = {$urandom, $urandom};
        handle_pool[0] = '0;
        handle_pool[1] = '1;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: empty list, extreme handles, overflow, ticks, stops, unknown mode
        send_beat(MODE_START, 64'h0, 32'h0, 0, 1, 32'h0, 32'h0);
        send_beat(MODE_START, '1, 32'hffff_ffff, 1, 0, 32'h8000_0000, 32'h0);
        send_beat(MODE_START, 64'h5, 32'h1234_5678, 1, 1, 32'h7fff_ffff, 32'h0);
        for (int i = 0; i < 10; i++)
            send_beat(MODE_START, 64'h77, i, 1, i == 9, 32'h0001_0000, 32'h0);
        send_beat(MODE_START, 64'h99, 32'h1, 1, 1, 32'h0000_0001, 32'h0);
        send_beat(MODE_START, 64'haa, 32'h2, 1, 1, 32'h0000_8000, 32'h0);
        send_beat(MODE_TICK, 64'h0, 32'h0, 0, 0, 32'h0, 32'h0003_0000);
        send_beat(MODE_TICK, 64'h0, 32'h0, 0, 0, 32'h0, 32'h7fff_ffff);
        send_beat(MODE_TICK, 64'h0, 32'h0, 0, 0, 32'h0, 32'h8000_0000);
        send_beat(MODE_STOP, '1, 32'h0, 0, 0, 32'h0, 32'h0);
        send_beat(MODE_STOP, 64'h1234, 32'h0, 0, 0, 32'h0, 32'h0);
        send_beat(2'd3, '1, '1, 1, 1, '1, '1);
        send_beat(MODE_TICK, '1, '1, 1, 0, '1, 32'h7fff_ffff);

        send_idle_pct = 25; take_idle_pct = 79;
        random_phase(150);
        send_idle_pct = 79; take_idle_pct = 25;
        random_phase(150);
        send_idle_pct = 0; take_idle_pct = 0;
        random_phase(150);
        s_axis_tvalid <= 0;

        // drain, then allow for a final slow beat
        while (event_board.pending_events.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (event_board.errors == 0 && event_board.pending_events.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
